>>> hw/rtl/sobel_edge_magnitude_rgb_unit_macros.svh
// Assertion macros shared by the Sobel edge magnitude RTL.
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_UNIT_MACROS_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_UNIT_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define SEMR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SEMR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/semr_pkg.sv
// Package: types and constants for the Sobel edge magnitude unit.
package semr_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int MAX_HEIGHT  = 4096;
    localparam int ROW_W       = 13;
    localparam int CFG_WIDTH_W = 11;
    localparam int CFG_HEIGHT_W = 13;
    localparam int CFG_DATA_W  = 13;
    localparam int PIX_W       = 24;
    localparam int SAT_LIMIT   = 65281;

    typedef struct packed {
        logic       command;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       frame_end;
    } out_word_t;

    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_GRAD,
        ST_SQUARE,
        ST_SUM,
        ST_ROOT,
        ST_ROUND,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic accept;
        logic update;
        logic grad;
        logic square;
        logic sum;
        logic root_step;
        logic round;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic produce;
        logic root_last;
        logic out_free;
    } status_t;

endpackage

>>> hw/rtl/semr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module semr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/semr_ctrl.sv
// Controller: sequences a word through update and, for a result, gradient, square root, output.
`include "sobel_edge_magnitude_rgb_unit_macros.svh"
module semr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  semr_pkg::status_t status,
    output semr_pkg::cmd_t    cmd
);

    semr_pkg::state_t state_reg;
    semr_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= semr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            semr_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = semr_pkg::ST_UPDATE;
                end
            end
            semr_pkg::ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = status.produce ? semr_pkg::ST_GRAD : semr_pkg::ST_IDLE;
            end
            semr_pkg::ST_GRAD:
            begin
                cmd.grad   = 1'b1;
                state_next = semr_pkg::ST_SQUARE;
            end
            semr_pkg::ST_SQUARE:
            begin
                cmd.square = 1'b1;
                state_next = semr_pkg::ST_SUM;
            end
            semr_pkg::ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = semr_pkg::ST_ROOT;
            end
            semr_pkg::ST_ROOT:
            begin
                cmd.root_step = 1'b1;
                if (status.root_last)
                begin
                    state_next = semr_pkg::ST_ROUND;
                end
            end
            semr_pkg::ST_ROUND:
            begin
                cmd.round  = 1'b1;
                state_next = semr_pkg::ST_EMIT;
            end
            semr_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = semr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = semr_pkg::ST_IDLE;
            end
        endcase
    end

    `SEMR_ASSERT_NEXT(a_accept_update, in_valid && in_ready, state_reg == semr_pkg::ST_UPDATE, "accept not followed by update")
    `SEMR_ASSERT_SAME(a_emit_free, cmd.emit, status.out_free, "emit into a full output register")
    `SEMR_ASSERT_NEXT(a_root_stay, state_reg == semr_pkg::ST_ROOT && !status.root_last, state_reg == semr_pkg::ST_ROOT, "root left early")

endmodule

>>> hw/rtl/semr_dp.sv
// Datapath: config, positions, line stores, window, gradients, square root, output register.
`include "sobel_edge_magnitude_rgb_unit_macros.svh"
module semr_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  semr_pkg::in_word_t                  in_data,
    input  logic                                cfg_valid,
    input  semr_pkg::cfg_reg_t                  cfg_index,
    input  logic [semr_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  semr_pkg::cmd_t                      cmd,
    output semr_pkg::status_t                   status,
    output logic                                out_valid,
    input  logic                                out_ready,
    output semr_pkg::out_word_t                 out_data
);

    logic [semr_pkg::CFG_WIDTH_W-1:0]  width_reg;
    logic [semr_pkg::CFG_HEIGHT_W-1:0] height_reg;
    logic [semr_pkg::ROW_W-1:0]        row_reg;
    logic [semr_pkg::ROW_W-1:0]        row_next;
    logic [semr_pkg::COL_W-1:0]        col_reg;
    logic [semr_pkg::COL_W-1:0]        col_next;
    logic                              flush_reg;
    logic [semr_pkg::PIX_W-1:0]        rgb_reg;
    logic [semr_pkg::PIX_W-1:0]        win_reg  [3][3];
    logic [semr_pkg::PIX_W-1:0]        mwin_reg [3][3];
    logic [semr_pkg::PIX_W-1:0]        mwin_next [3][3];
    logic                              fe_reg;
    logic [9:0]                        ux_reg [3];
    logic [9:0]                        uy_reg [3];
    logic [9:0]                        ux_next [3];
    logic [9:0]                        uy_next [3];
    logic [19:0]                       sqx_reg [3];
    logic [19:0]                       sqy_reg [3];
    logic [16:0]                       s_reg [3];
    logic                              sat_reg [3];
    logic [7:0]                        root_reg [3];
    logic [7:0]                        root_next [3];
    logic [7:0]                        res_reg [3];
    logic [7:0]                        res_next [3];
    logic [2:0]                        bit_reg;
    logic                              out_valid_reg;
    semr_pkg::out_word_t               out_data_reg;

    logic [semr_pkg::CFG_WIDTH_W-1:0]  w_eff;
    logic [semr_pkg::CFG_HEIGHT_W-1:0] h_eff;
    logic [semr_pkg::CFG_WIDTH_W-1:0]  col_ext;
    logic [semr_pkg::CFG_WIDTH_W-1:0]  col_inc;
    logic                              produce;
    logic                              fe;
    logic [semr_pkg::PIX_W-1:0]        pix_v;
    logic [semr_pkg::PIX_W-1:0]        top;
    logic [semr_pkg::PIX_W-1:0]        md;
    logic [semr_pkg::ROW_W-1:0]        cr;
    logic                              row_ok [3];
    logic                              col_ok [3];
    logic                              in_img;

    semr_ram #(.WIDTH(semr_pkg::PIX_W), .DEPTH(semr_pkg::MAX_WIDTH)) u_upper (
        .clk   (clk),
        .we    (cmd.update),
        .waddr (col_reg),
        .wdata (md),
        .raddr (col_reg),
        .rdata (top)
    );

    semr_ram #(.WIDTH(semr_pkg::PIX_W), .DEPTH(semr_pkg::MAX_WIDTH)) u_middle (
        .clk   (clk),
        .we    (cmd.update),
        .waddr (col_reg),
        .wdata (pix_v),
        .raddr (col_reg),
        .rdata (md)
    );

    always_comb
    begin
        if (width_reg == '0)
            w_eff = 11'd1;
        else if (width_reg > 11'(semr_pkg::MAX_WIDTH))
            w_eff = 11'(semr_pkg::MAX_WIDTH);
        else
            w_eff = width_reg;
        if (height_reg == '0)
            h_eff = 13'd1;
        else if (height_reg > 13'(semr_pkg::MAX_HEIGHT))
            h_eff = 13'(semr_pkg::MAX_HEIGHT);
        else
            h_eff = height_reg;
    end

    assign col_ext = {1'b0, col_reg};
    assign col_inc = col_ext + 11'd1;
    assign produce = (row_reg >= 13'd2) || (row_reg == 13'd1 && col_reg != '0);
    assign fe      = produce && (row_reg > h_eff) && (col_reg == '0);
    assign pix_v   = (!flush_reg && row_reg < h_eff) ? rgb_reg : '0;

    always_comb
    begin
        if (fe)
        begin
            row_next = '0;
            col_next = '0;
        end
        else if (col_inc >= w_eff)
        begin
            row_next = row_reg + 13'd1;
            col_next = '0;
        end
        else
        begin
            row_next = row_reg;
            col_next = col_inc[semr_pkg::COL_W-1:0];
        end
    end

    // neighbour masks for the centre pixel
    always_comb
    begin
        if (col_reg == '0)
        begin
            cr        = row_reg - 13'd2;
            col_ok[0] = w_eff >= 11'd2;
            col_ok[1] = 1'b1;
            col_ok[2] = 1'b0;
        end
        else
        begin
            cr        = row_reg - 13'd1;
            col_ok[0] = (col_ext >= 11'd2) && ((col_ext - 11'd2) < w_eff);
            col_ok[1] = (col_ext - 11'd1) < w_eff;
            col_ok[2] = col_ext < w_eff;
        end
        in_img    = cr < h_eff;
        row_ok[0] = in_img && (cr != '0);
        row_ok[1] = in_img;
        row_ok[2] = in_img && ({1'b0, cr} + 14'd1 < {1'b0, h_eff});
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                mwin_next[r][c] = '0;
            end
        end
        for (int r = 0; r < 3; r++)
        begin
            if (col_reg == '0)
            begin
                mwin_next[r][0] = (row_ok[r] && col_ok[0]) ? win_reg[r][1] : '0;
                mwin_next[r][1] = (row_ok[r] && col_ok[1]) ? win_reg[r][2] : '0;
            end
            else
            begin
                mwin_next[r][0] = (row_ok[r] && col_ok[0]) ? win_reg[r][1] : '0;
                mwin_next[r][1] = (row_ok[r] && col_ok[1]) ? win_reg[r][2] : '0;
            end
        end
        if (col_reg != '0)
        begin
            mwin_next[0][2] = (row_ok[0] && col_ok[2]) ? top : '0;
            mwin_next[1][2] = (row_ok[1] && col_ok[2]) ? md : '0;
            mwin_next[2][2] = (row_ok[2] && col_ok[2]) ? pix_v : '0;
        end
    end

    // Sobel sums per channel, channel 0 is red
    always_comb
    begin
        logic [9:0] ap;
        logic [9:0] an;
        logic [9:0] bp;
        logic [9:0] bn;
        for (int ch = 0; ch < 3; ch++)
        begin
            ap = {2'b0, mwin_reg[0][2][(2-ch)*8 +: 8]} + {1'b0, mwin_reg[1][2][(2-ch)*8 +: 8], 1'b0}
               + {2'b0, mwin_reg[2][2][(2-ch)*8 +: 8]};
            an = {2'b0, mwin_reg[0][0][(2-ch)*8 +: 8]} + {1'b0, mwin_reg[1][0][(2-ch)*8 +: 8], 1'b0}
               + {2'b0, mwin_reg[2][0][(2-ch)*8 +: 8]};
            bp = {2'b0, mwin_reg[2][0][(2-ch)*8 +: 8]} + {1'b0, mwin_reg[2][1][(2-ch)*8 +: 8], 1'b0}
               + {2'b0, mwin_reg[2][2][(2-ch)*8 +: 8]};
            bn = {2'b0, mwin_reg[0][0][(2-ch)*8 +: 8]} + {1'b0, mwin_reg[0][1][(2-ch)*8 +: 8], 1'b0}
               + {2'b0, mwin_reg[0][2][(2-ch)*8 +: 8]};
            ux_next[ch] = (ap >= an) ? ap - an : an - ap;
            uy_next[ch] = (bp >= bn) ? bp - bn : bn - bp;
        end
    end

    // one bit of the root per step, then round to nearest
    always_comb
    begin
        logic [7:0]  trial;
        logic [15:0] tsq;
        logic [16:0] lim;
        for (int ch = 0; ch < 3; ch++)
        begin
            trial = root_reg[ch] | (8'd1 << bit_reg);
            tsq   = 16'(trial) * 16'(trial);
            root_next[ch] = ({1'b0, tsq} <= s_reg[ch]) ? trial : root_reg[ch];
            lim   = {1'b0, 16'(root_reg[ch]) * 16'(root_reg[ch])} + 17'(root_reg[ch]);
            if (sat_reg[ch])
                res_next[ch] = 8'hff;
            else if (s_reg[ch] > lim)
                res_next[ch] = root_reg[ch] + 8'd1;
            else
                res_next[ch] = root_reg[ch];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= 11'd640;
            height_reg    <= 13'd480;
            row_reg       <= '0;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    win_reg[r][c] <= '0;
                end
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    semr_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_data[semr_pkg::CFG_WIDTH_W-1:0];
                    semr_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.update)
            begin
                row_reg <= row_next;
                col_reg <= col_next;
                for (int r = 0; r < 3; r++)
                begin
                    win_reg[r][0] <= win_reg[r][1];
                    win_reg[r][1] <= win_reg[r][2];
                end
                win_reg[0][2] <= top;
                win_reg[1][2] <= md;
                win_reg[2][2] <= pix_v;
            end
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            flush_reg <= in_data.command;
            rgb_reg   <= {in_data.red, in_data.green, in_data.blue};
        end
        if (cmd.update)
        begin
            fe_reg   <= fe;
            mwin_reg <= mwin_next;
        end
        if (cmd.sum)
            bit_reg <= 3'd7;
        else if (cmd.root_step)
            bit_reg <= bit_reg - 3'd1;
        for (int ch = 0; ch < 3; ch++)
        begin
            if (cmd.grad)
            begin
                ux_reg[ch] <= ux_next[ch];
                uy_reg[ch] <= uy_next[ch];
            end
            if (cmd.square)
            begin
                sqx_reg[ch] <= 20'(ux_reg[ch]) * 20'(ux_reg[ch]);
                sqy_reg[ch] <= 20'(uy_reg[ch]) * 20'(uy_reg[ch]);
            end
            if (cmd.sum)
            begin
                s_reg[ch]    <= 17'({1'b0, sqx_reg[ch]} + {1'b0, sqy_reg[ch]});
                sat_reg[ch]  <= ({1'b0, sqx_reg[ch]} + {1'b0, sqy_reg[ch]}) >= 21'(semr_pkg::SAT_LIMIT);
                root_reg[ch] <= '0;
            end
            if (cmd.root_step)
                root_reg[ch] <= root_next[ch];
            if (cmd.round)
                res_reg[ch] <= res_next[ch];
        end
        if (cmd.emit)
        begin
            out_data_reg.out_red   <= res_reg[0];
            out_data_reg.out_green <= res_reg[1];
            out_data_reg.out_blue  <= res_reg[2];
            out_data_reg.frame_end <= fe_reg;
        end
    end

    assign status.produce   = produce;
    assign status.root_last = bit_reg == 3'd0;
    assign status.out_free  = !out_valid_reg || out_ready;
    assign out_valid        = out_valid_reg;
    assign out_data         = out_data_reg;

    `SEMR_ASSERT_NEXT(a_bit_step, cmd.root_step && bit_reg != 3'd0, bit_reg == $past(bit_reg) - 3'd1, "root bit counter skipped")
    `SEMR_ASSERT_NEXT(a_fe_wrap, cmd.update && fe, row_reg == '0 && col_reg == '0, "frame end did not rewind position")
    `SEMR_ASSERT_NEXT(a_sat_max, cmd.round && sat_reg[0], res_reg[0] == 8'hff, "saturated red not 255")

endmodule

>>> hw/rtl/sobel_edge_magnitude_rgb_unit.sv
// Top level: streaming 3x3 Sobel edge magnitude on RGB words.
// Words are taken one at a time: a word with no result passes through accept and update;
// a word with a result goes on through gradient, square, sum, root, round and emit into the output register.
// The eight-step square-root unit and the line-store read before the window shift lie on this path.
// The output register lets the next word enter while a result waits to be taken.
// Reset clears position, window and config (width 640, height 480); line stores are not cleared.
module sobel_edge_magnitude_rgb_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  semr_pkg::in_word_t              in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output semr_pkg::out_word_t             out_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  semr_pkg::cfg_reg_t              cfg_index,
    input  logic [semr_pkg::CFG_DATA_W-1:0] cfg_data
);

    semr_pkg::cmd_t    cmd;
    semr_pkg::status_t status;

    assign cfg_ready = 1'b1;

    semr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    semr_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
